FILE: src/acp_pkg.sv
// Shared types, character codes and response codes for the AT command line parser.
// No dependencies; imported by acp_exec and at_command_line_parser_core.
package acp_pkg;

   // characters
   localparam logic [7:0] CH_BS    = 8'h08;
   localparam logic [7:0] CH_HT    = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SP    = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_2     = 8'h32;
   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_QM    = 8'h3F;
   localparam logic [7:0] CH_A     = 8'h41;
   localparam logic [7:0] CH_C     = 8'h43;
   localparam logic [7:0] CH_F     = 8'h46;
   localparam logic [7:0] CH_I     = 8'h49;
   localparam logic [7:0] CH_O     = 8'h4F;
   localparam logic [7:0] CH_T     = 8'h54;
   localparam logic [7:0] CH_LA    = 8'h61;
   localparam logic [7:0] CH_LZ    = 8'h7A;
   localparam logic [7:0] CASE_BIT = 8'h20;

   // response codes
   localparam logic [2:0] RC_OK      = 3'd0;
   localparam logic [2:0] RC_ERROR   = 3'd1;
   localparam logic [2:0] RC_CONNECT = 3'd2;
   localparam logic [2:0] RC_REPORT  = 3'd3;
   localparam logic [2:0] RC_LIST    = 3'd4;

   // result word kinds
   localparam logic KIND_ECHO = 1'b0;
   localparam logic KIND_RESP = 1'b1;

   // parse phases
   localparam logic [1:0] PH_IDLE   = 2'd0;
   localparam logic [1:0] PH_PREFIX = 2'd1;
   localparam logic [1:0] PH_BODY   = 2'd2;

   typedef struct packed {
      logic       clear;
      logic       push;
      logic [7:0] data;
   } acp_exec_ctl_type;

   typedef struct packed {
      logic [2:0] code;
      logic       online;
      logic       set_flags;
      logic       rts;
      logic       cts;
   } acp_exec_res_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] ch;
      logic [2:0] code;
      logic       rts;
      logic       cts;
      logic       online;
      logic       last;
   } acp_item_type;

   function automatic logic [7:0] to_upper(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c inside {[CH_LA:CH_LZ]}) begin
         r = c & ~CASE_BIT;
      end
      return r;
   endfunction

   function automatic logic is_blank(input logic [7:0] c);
      return (c == CH_SP) || (c inside {[CH_HT:CH_CR]});
   endfunction

endpackage

FILE: src/acp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module acp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/acp_exec.sv
// Command executor: compacts a streamed line (drop blanks, upper-case) and decodes it.
// Depends on acp_pkg.
module acp_exec
   import acp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  acp_exec_ctl_type ctl,
   output acp_exec_res_type res
);

   // count saturates at 9: a line of nine or more kept characters matches only the O command
   logic [3:0] cnt_ff, cnt_in;
   logic [7:0] cbuf_ff [8];
   logic [7:0] up;
   logic       keep;
   logic       head;
   logic       b5_ok, b7_ok;

   assign up   = to_upper(ctl.data);
   assign keep = ctl.push && !is_blank(ctl.data);

   always_comb begin
      cnt_in = cnt_ff;
      if (ctl.clear) begin
         cnt_in = 4'd0;
      end else if (keep && cnt_ff < 4'd9) begin
         cnt_in = cnt_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 4'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!ctl.clear && keep && cnt_ff < 4'd8) begin
         cbuf_ff[cnt_ff[2:0]] <= up;
      end
   end

   assign head = cbuf_ff[0] == CH_PLUS && cbuf_ff[1] == CH_I &&
                 cbuf_ff[2] == CH_F && cbuf_ff[3] == CH_C && cbuf_ff[4] == CH_EQ;
   assign b5_ok = cbuf_ff[5] == CH_0 || cbuf_ff[5] == CH_2;
   assign b7_ok = cbuf_ff[7] == CH_0 || cbuf_ff[7] == CH_2;

   always_comb begin
      res = '{code: RC_ERROR, online: 1'b0, set_flags: 1'b0, rts: 1'b0, cts: 1'b0};
      if (cnt_ff == 4'd0) begin
         res.code = RC_OK;
      end else if (cbuf_ff[0] == CH_O) begin
         res.code   = RC_CONNECT;
         res.online = 1'b1;
      end else if (cnt_ff == 4'd5 && cbuf_ff[0] == CH_PLUS && cbuf_ff[1] == CH_I &&
                   cbuf_ff[2] == CH_F && cbuf_ff[3] == CH_C && cbuf_ff[4] == CH_QM) begin
         res.code = RC_REPORT;
      end else if (cnt_ff == 4'd5 && head) begin
         res.code = RC_OK;
      end else if (cnt_ff == 4'd6 && head && cbuf_ff[5] == CH_QM) begin
         res.code = RC_LIST;
      end else if (cnt_ff == 4'd6 && head && b5_ok) begin
         // short set form: one value for both directions
         res.code      = RC_OK;
         res.set_flags = 1'b1;
         res.rts       = cbuf_ff[5] == CH_2;
         res.cts       = cbuf_ff[5] == CH_2;
      end else if (cnt_ff == 4'd8 && head && b5_ok && b7_ok && cbuf_ff[6] == CH_COMMA) begin
         res.code      = RC_OK;
         res.set_flags = 1'b1;
         res.rts       = cbuf_ff[5] == CH_2;
         res.cts       = cbuf_ff[7] == CH_2;
      end
   end

endmodule

FILE: src/at_command_line_parser_core.sv
// Top level of the AT command line parser: sequencer, line memory, result register.
// Depends on acp_pkg, acp_ram and acp_exec.
//
// Takes one received character per req word and answers with up to three rsp words
// (echoes and/or one command response, the final one flagged by rsp_last). An
// ordinary character is taken while idle and its echo word is loaded in ST_ECHO;
// a backspace steps through ST_BS1, ST_BS2 and ST_BS3 (three echo words); a line
// end ("AT...<CR>" or "A/") walks the stored line through the single read port
// of the line memory, one character per cycle, in ST_EXEC before ST_DECODE and
// ST_RESP; an echoed "A/" passes through ST_ECHO first. req_ready is low while a
// word is being worked; a finished result may still sit in the output register
// while the next character is taken, and the sequencer only stalls when it must
// load a new word into a full register.
// The line memory holds two banks of LINE_DEPTH bytes: the current line is typed
// into one bank and, at the line end, the banks swap roles, so the saved previous
// line is never copied. Its contents are undefined after reset and need no
// clearing pass; only written entries are ever read.
module at_command_line_parser_core
   import acp_pkg::*;
#(
   parameter int LINE_DEPTH = 64
) (
   input  logic       clock,
   input  logic       reset,
   // configuration
   input  logic       csr_write_enable,
   input  logic       csr_echo_enable,
   // received characters
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   // results
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_kind,
   output logic [7:0] rsp_echo_char,
   output logic [2:0] rsp_response_code,
   output logic       rsp_rts_flag,
   output logic       rsp_cts_flag,
   output logic       rsp_go_online,
   output logic       rsp_last
);

   localparam int LEN_W   = $clog2(LINE_DEPTH);
   localparam int RAM_AW  = LEN_W + 1;
   localparam int RAM_DEP = 2 ** RAM_AW;
   localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(LINE_DEPTH - 1);

   // sequencer states
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_ECHO   = 3'd1;
   localparam logic [2:0] ST_BS1    = 3'd2;
   localparam logic [2:0] ST_BS2    = 3'd3;
   localparam logic [2:0] ST_BS3    = 3'd4;
   localparam logic [2:0] ST_EXEC   = 3'd5;
   localparam logic [2:0] ST_DECODE = 3'd6;
   localparam logic [2:0] ST_RESP   = 3'd7;

   logic [2:0]       state_ff, state_in;
   logic [1:0]       phase_ff, phase_in;
   logic [LEN_W-1:0] line_len_ff, line_len_in;
   logic [LEN_W-1:0] prev_len_ff, prev_len_in;
   logic [LEN_W-1:0] idx_ff, idx_in;
   logic             prev_bank_ff, prev_bank_in;   // bank that holds the previous line
   logic             pend_ff, pend_in;             // a line read is in flight
   logic             exec_after_ff, exec_after_in; // echo word is followed by a response
   logic [7:0]       ch_ff, ch_in;
   logic             echo_ff;
   logic             rts_ff, rts_in;
   logic             cts_ff, cts_in;

   acp_item_type     out_ff, item;
   logic             out_valid_ff;
   logic             out_load;
   logic             out_free;

   logic              accept;
   logic [7:0]        up;
   logic              ram_we, ram_re;
   logic [RAM_AW-1:0] ram_waddr, ram_raddr;
   logic [7:0]        ram_rdata;

   acp_exec_ctl_type exec_ctl;
   acp_exec_res_type exec_res;

   assign req_ready = state_ff == ST_IDLE;
   assign accept    = req_valid && req_ready;
   assign up        = to_upper(req_in_byte);
   assign out_free  = !out_valid_ff || rsp_ready;

   // line memory: body characters go to the bank that is not the previous line
   assign ram_waddr = {~prev_bank_ff, line_len_ff};
   assign ram_raddr = {prev_bank_ff, idx_ff};

   acp_ram #(
      .WIDTH(8),
      .DEPTH(RAM_DEP)
   ) u_line_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(req_in_byte),
      .rd_en  (ram_re),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   // executor sees each stored character the cycle after its read
   assign exec_ctl.clear = accept;
   assign exec_ctl.push  = pend_ff;
   assign exec_ctl.data  = ram_rdata;

   acp_exec u_exec (
      .clock(clock),
      .reset(reset),
      .ctl  (exec_ctl),
      .res  (exec_res)
   );

   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      line_len_in   = line_len_ff;
      prev_len_in   = prev_len_ff;
      idx_in        = idx_ff;
      prev_bank_in  = prev_bank_ff;
      pend_in       = 1'b0;
      exec_after_in = exec_after_ff;
      ch_in         = ch_ff;
      rts_in        = rts_ff;
      cts_in        = cts_ff;
      ram_we        = 1'b0;
      ram_re        = 1'b0;
      out_load      = 1'b0;
      item          = '{kind: KIND_ECHO, ch: 8'd0, code: RC_OK, rts: rts_ff, cts: cts_ff,
                        online: 1'b0, last: 1'b0};

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               idx_in        = '0;
               ch_in         = req_in_byte;
               exec_after_in = 1'b0;
               case (phase_ff)
                  PH_BODY: begin
                     if (req_in_byte == CH_CR) begin
                        // line end: current bank becomes the previous line, run it
                        prev_bank_in = ~prev_bank_ff;
                        prev_len_in  = line_len_ff;
                        phase_in     = PH_IDLE;
                        state_in     = ST_EXEC;
                     end else if (req_in_byte == CH_BS) begin
                        if (line_len_ff != '0) begin
                           line_len_in = line_len_ff - LEN_W'(1);
                           if (echo_ff) begin
                              state_in = ST_BS1;
                           end
                        end
                     end else if (line_len_ff < LEN_MAX) begin
                        ram_we      = 1'b1;
                        line_len_in = line_len_ff + LEN_W'(1);
                        if (echo_ff) begin
                           state_in = ST_ECHO;
                        end
                     end
                  end
                  PH_PREFIX: begin
                     if (req_in_byte == CH_SLASH) begin
                        // repeat the previous line
                        phase_in      = PH_IDLE;
                        exec_after_in = 1'b1;
                        state_in      = echo_ff ? ST_ECHO : ST_EXEC;
                     end else begin
                        if (up == CH_T) begin
                           line_len_in = '0;
                           phase_in    = PH_BODY;
                        end else begin
                           phase_in = PH_IDLE;
                        end
                        if (echo_ff) begin
                           state_in = ST_ECHO;
                        end
                     end
                  end
                  default: begin
                     // hunting for the prefix; unused phase code acts as idle
                     phase_in = (up == CH_A) ? PH_PREFIX : PH_IDLE;
                     if (echo_ff) begin
                        state_in = ST_ECHO;
                     end
                  end
               endcase
            end
         end
         ST_ECHO: begin
            if (out_free) begin
               out_load  = 1'b1;
               item.ch   = ch_ff;
               item.last = !exec_after_ff;
               state_in  = exec_after_ff ? ST_EXEC : ST_IDLE;
            end
         end
         ST_BS1: begin
            if (out_free) begin
               out_load = 1'b1;
               item.ch  = CH_BS;
               state_in = ST_BS2;
            end
         end
         ST_BS2: begin
            if (out_free) begin
               out_load = 1'b1;
               item.ch  = CH_SP;
               state_in = ST_BS3;
            end
         end
         ST_BS3: begin
            if (out_free) begin
               out_load  = 1'b1;
               item.ch   = CH_BS;
               item.last = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         ST_EXEC: begin
            // one stored character read per cycle
            if (idx_ff < prev_len_ff) begin
               ram_re  = 1'b1;
               idx_in  = idx_ff + LEN_W'(1);
               pend_in = 1'b1;
            end else if (!pend_ff) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (exec_res.set_flags) begin
               rts_in = exec_res.rts;
               cts_in = exec_res.cts;
            end
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (out_free) begin
               out_load    = 1'b1;
               item.kind   = KIND_RESP;
               item.code   = exec_res.code;
               item.online = exec_res.online;
               item.last   = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_IDLE;
         line_len_ff  <= '0;
         prev_len_ff  <= '0;
         idx_ff       <= '0;
         prev_bank_ff <= 1'b0;
         pend_ff      <= 1'b0;
         echo_ff      <= 1'b1;
         rts_ff       <= 1'b0;
         cts_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         line_len_ff  <= line_len_in;
         prev_len_ff  <= prev_len_in;
         idx_ff       <= idx_in;
         prev_bank_ff <= prev_bank_in;
         pend_ff      <= pend_in;
         rts_ff       <= rts_in;
         cts_ff       <= cts_in;
         if (csr_write_enable) begin
            echo_ff <= csr_echo_enable;
         end
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      exec_after_ff <= exec_after_in;
      ch_ff         <= ch_in;
      if (out_load) begin
         out_ff <= item;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_kind          = out_ff.kind;
   assign rsp_echo_char     = out_ff.ch;
   assign rsp_response_code = out_ff.code;
   assign rsp_rts_flag      = out_ff.rts;
   assign rsp_cts_flag      = out_ff.cts;
   assign rsp_go_online     = out_ff.online;
   assign rsp_last          = out_ff.last;

`ifndef ASSERT_OFF
   // a line end always returns to prefix hunting and saves the typed length
   a_line_end: assert property (@(posedge clock) disable iff (reset)
      accept && phase_ff == PH_BODY && req_in_byte == CH_CR
      |=> phase_ff == PH_IDLE && prev_len_ff == $past(line_len_ff))
      else $error("line end did not save length or leave body phase");

   // line reads only happen while walking the line
   a_pend_exec: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> state_ff == ST_EXEC)
      else $error("line read data arrived outside the walk");

   // the line memory is never written during a walk
   a_no_write_walk: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EXEC |-> !ram_we)
      else $error("line memory written during execution");

   // only a CONNECT response asks to go online
   a_online_connect: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_go_online |-> rsp_kind == KIND_RESP && rsp_response_code == RC_CONNECT)
      else $error("go_online without CONNECT");
`endif

endmodule
